FILE: rtl/core/connect_failure_backoff_table_unit_assert.svh
// Assertion macros for the connect-failure back-off table
`ifndef CONNECT_FAILURE_BACKOFF_TABLE_UNIT_ASSERT_SVH
`define CONNECT_FAILURE_BACKOFF_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define CFBT_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfbt: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define CFBT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfbt: next-cycle check failed");

`endif

FILE: rtl/core/cfbt_pkg.sv
// Shared types and constants for the connect-failure back-off table
package cfbt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ADDR_W      = 64;
  localparam int V4_W        = 32;
  localparam int TIME_W      = 40;
  localparam int CNT_W       = 4;
  localparam int HOLD_W      = 13;
  localparam int GUARD_W     = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CNT_W-1:0]   MAX_FAIL_COUNT  = 4'd10;
  localparam logic [CNT_W-1:0]   BLOCK_MIN_COUNT = 4'd2;
  localparam logic [CNT_W-1:0]   FIRST_COUNT     = 4'd1;
  localparam logic [HOLD_W-1:0]  HOLD_RESET      = 13'd3840;
  localparam logic [GUARD_W-1:0] GUARD_RESET     = 16'd120;

  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_OFF     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_GUARD = 1'b1;

  localparam logic OP_MATCH  = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } cfbt_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } cfbt_cmd_t;

endpackage

FILE: rtl/core/cfbt_ctrl.sv
// Controller: accept a beat, then run the execute state
module cfbt_ctrl
  import cfbt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output cfbt_cmd_t cmd
);

  cfbt_state_t state_r;
  cfbt_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    busy        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy      = 1'b1;
        cmd.exec  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/cfbt_dp.sv
// Datapath: entry table, key compare, elapsed-time checks and result registers
module cfbt_dp
  import cfbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfbt_cmd_t             cmd,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_operation,
  input  logic                  in_is_v6,
  input  logic [ADDR_W-1:0]     in_addr_high,
  input  logic [ADDR_W-1:0]     in_addr_low,
  input  logic                  in_problem,
  input  logic [TIME_W-1:0]     in_now_seconds,
  output logic                  out_valid,
  output logic                  out_blocked,
  output logic                  out_status
);

  logic [HOLD_W-1:0]  hold_r;
  logic [GUARD_W-1:0] guard_r;

  logic [TABLE_DEPTH-1:0] valid_r;
  logic                   ent_fam_r  [TABLE_DEPTH];
  logic [ADDR_W-1:0]      ent_hi_r   [TABLE_DEPTH];
  logic [ADDR_W-1:0]      ent_lo_r   [TABLE_DEPTH];
  logic [CNT_W-1:0]       ent_cnt_r  [TABLE_DEPTH];
  logic [TIME_W-1:0]      ent_time_r [TABLE_DEPTH];

  logic                   op_r;
  logic                   fam_r;
  logic [ADDR_W-1:0]      hi_r;
  logic [ADDR_W-1:0]      lo_r;
  logic                   prob_r;
  logic [TIME_W-1:0]      now_r;
  logic [TABLE_DEPTH-1:0] hit_r;
  logic [TABLE_DEPTH-1:0] free_oh_r;

  logic                   valid_out_r;
  logic                   blocked_r;
  logic                   status_r;

  logic [ADDR_W-1:0]      key_hi;
  logic [ADDR_W-1:0]      key_lo;
  logic [TABLE_DEPTH-1:0] hit_vec;
  logic [TABLE_DEPTH-1:0] free_vec;
  logic [TABLE_DEPTH-1:0] free_oh;

  logic [CNT_W-1:0]       sel_cnt;
  logic [TIME_W-1:0]      sel_time;
  logic                   any_hit;
  logic                   any_free;
  logic [TIME_W-1:0]      elapsed;
  logic                   guard_ok;
  logic                   do_fail;
  logic                   do_clear;
  logic [CNT_W-1:0]       cnt_inc;

  // Normalize the key: IPv4 keeps only the low 32 address bits
  assign key_hi = in_is_v6 ? in_addr_high : '0;
  assign key_lo = in_is_v6 ? in_addr_low : {{(ADDR_W-V4_W){1'b0}}, in_addr_low[V4_W-1:0]};

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_vec[i] = valid_r[i] && (ent_fam_r[i] == in_is_v6) &&
                   (ent_hi_r[i] == key_hi) && (ent_lo_r[i] == key_lo);
    end
  end

  assign free_vec = ~valid_r;
  assign free_oh  = free_vec & (~free_vec + TABLE_DEPTH'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r  <= HOLD_RESET;
      guard_r <= GUARD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HOLD_OFF:     hold_r  <= cfg_data[HOLD_W-1:0];
        CFG_REPEAT_GUARD: guard_r <= cfg_data[GUARD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Capture the beat and the compare results
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_operation;
      fam_r     <= in_is_v6;
      hi_r      <= key_hi;
      lo_r      <= key_lo;
      prob_r    <= in_problem;
      now_r     <= in_now_seconds;
      hit_r     <= hit_vec;
      free_oh_r <= free_oh;
    end
  end

  always_comb begin
    sel_cnt  = '0;
    sel_time = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      sel_cnt  = sel_cnt | (ent_cnt_r[i] & {CNT_W{hit_r[i]}});
      sel_time = sel_time | (ent_time_r[i] & {TIME_W{hit_r[i]}});
    end
  end

  assign any_hit  = |hit_r;
  assign any_free = |free_oh_r;
  assign elapsed  = now_r - sel_time;
  assign guard_ok = elapsed >= TIME_W'(guard_r);
  assign do_fail  = (op_r == OP_UPDATE) && prob_r;
  assign do_clear = (op_r == OP_UPDATE) && !prob_r;
  assign cnt_inc  = (sel_cnt < MAX_FAIL_COUNT) ? sel_cnt + CNT_W'(1) : MAX_FAIL_COUNT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.exec) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (do_fail && !any_hit && free_oh_r[i]) begin
          valid_r[i] <= 1'b1;
        end else if (do_clear && hit_r[i]) begin
          valid_r[i] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && do_fail) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (hit_r[i] && guard_ok) begin
          ent_cnt_r[i]  <= cnt_inc;
          ent_time_r[i] <= now_r;
        end else if (!any_hit && free_oh_r[i]) begin
          ent_fam_r[i]  <= fam_r;
          ent_hi_r[i]   <= hi_r;
          ent_lo_r[i]   <= lo_r;
          ent_cnt_r[i]  <= FIRST_COUNT;
          ent_time_r[i] <= now_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_out_r <= 1'b0;
    end else begin
      valid_out_r <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      blocked_r <= (op_r == OP_MATCH) && any_hit && (sel_cnt >= BLOCK_MIN_COUNT) &&
                   (elapsed < TIME_W'(hold_r));
      status_r  <= do_fail && !any_hit && !any_free;
    end
  end

  assign out_valid   = valid_out_r;
  assign out_blocked = blocked_r;
  assign out_status  = status_r;

endmodule

FILE: rtl/core/connect_failure_backoff_table_unit.sv
// Top level of the connect-failure back-off table
// An item is accepted when start is high and busy is low. In the accept
// cycle the key is compared against all 16 entries at once, and in the
// following cycle (busy high) the matching entry is read, the elapsed-time
// checks run and the entry is written. The result appears on
// out_blocked/out_status with a one-cycle out_valid strobe in the cycle
// after that, which is also the earliest cycle a new item is taken. The
// receiver cannot stall: every result beat must be taken in its strobe
// cycle. The configuration port is always ready; write it only while no
// item is in flight. No clearing pass runs after reset; the table is empty
// at once.
module connect_failure_backoff_table_unit
  import cfbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_operation,
  input  logic                  in_is_v6,
  input  logic [ADDR_W-1:0]     in_addr_high,
  input  logic [ADDR_W-1:0]     in_addr_low,
  input  logic                  in_problem,
  input  logic [TIME_W-1:0]     in_now_seconds,
  output logic                  out_valid,
  output logic                  out_blocked,
  output logic                  out_status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  `include "connect_failure_backoff_table_unit_assert.svh"

  cfbt_cmd_t cmd;

  assign cfg_ready = 1'b1;

  cfbt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  cfbt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_operation   (in_operation),
    .in_is_v6       (in_is_v6),
    .in_addr_high   (in_addr_high),
    .in_addr_low    (in_addr_low),
    .in_problem     (in_problem),
    .in_now_seconds (in_now_seconds),
    .out_valid      (out_valid),
    .out_blocked    (out_blocked),
    .out_status     (out_status)
  );

  `CFBT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `CFBT_ASSERT_NEXT(a_exec_result, busy, out_valid && !busy)
  `CFBT_ASSERT_IMPLY(a_result_idle, out_valid, !busy)
  `CFBT_ASSERT_IMPLY(a_result_excl, out_valid, !(out_blocked && out_status))

endmodule
